// ----- design/pmcc_pkg.sv -----
// Shared types and constants for the particle concentration correction block.
// Depends on nothing; imported by pm_concentration_correction.
package pmcc_pkg;

   // Which rule produces the result of a request
   typedef enum logic [1:0] {
      KIND_SMALL  = 2'd0,
      KIND_CURVE  = 2'd1,
      KIND_OFFSET = 2'd2
   } kind_type;

   // Curve select codes
   localparam logic CURVE_STD = 1'b0;
   localparam logic CURVE_ENV = 1'b1;

   // Fitted ranges and offsets above them
   localparam logic [15:0] STD_LIMIT  = 16'd896;
   localparam logic [15:0] STD_OFFSET = 16'd304;
   localparam logic [15:0] ENV_LIMIT  = 16'd583;
   localparam logic [15:0] ENV_OFFSET = 16'd618;
   localparam logic [15:0] MAX16      = 16'hFFFF;

   // Control that travels beside the arithmetic
   typedef struct packed {
      kind_type    kind;
      logic [16:0] direct;
      logic        force_sat;
   } ctrl_type;

endpackage

// ----- design/pm_concentration_correction.sv -----
// Particle concentration correction: top level with the full pipeline.
// Depends on pmcc_pkg for codes, curve constants and the control struct.
//
// One request in, one response out, accepted in every cycle when the output
// side keeps up. A request passes 21 register stages: input capture, the two
// products B*x and K*x, the denominator A - B*x, an overflow check of the
// quotient, sixteen restoring-division stages (one quotient bit each), and
// the output register. Throughput is one per cycle while the output drains.
// The whole pipeline holds while a response waits and rsp_tready is low.
// Raw values 0 and 1 give 1; beyond the fitted range a fixed offset is added;
// results above 65535 are clamped to 65535 with the saturated flag set.
module pm_concentration_correction
   import pmcc_pkg::*;
#(
   parameter int FRAC_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] raw_value
   input  logic        req_tuser,   // [0] curve_select
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] corrected_value
   output logic        rsp_tuser    // [0] saturated
);

   // Widths of the fixed-point values
   localparam int AW = FRAC_BITS + 1;   // A and K, both below 2.0
   localparam int BW = FRAC_BITS - 9;   // B, below 2^-10
   localparam int PW = BW + 16;         // B*x
   localparam int NW = FRAC_BITS + 17;  // K*x, also holds den << 16
   localparam int QB = 16;              // quotient bits

   // Rounded fixed-point constants
   localparam logic [AW-1:0] K_FX =
      AW'(((64'd108 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [AW-1:0] A_STD_FX =
      AW'(((64'd1585325 << FRAC_BITS) + 64'd500000) / 64'd1000000);
   localparam logic [BW-1:0] B_STD_FX =
      BW'(((64'd9357 << FRAC_BITS) + 64'd5000000) / 64'd10000000);
   localparam logic [AW-1:0] A_ENV_FX =
      AW'(((64'd1061263 << FRAC_BITS) + 64'd500000) / 64'd1000000);
   localparam logic [BW-1:0] B_ENV_FX =
      BW'(((64'd9423 << FRAC_BITS) + 64'd5000000) / 64'd10000000);

   logic advance;

   // Stage 1: capture
   logic        s1_vld_ff;
   logic [15:0] s1_x_ff;
   logic        s1_sel_ff;

   // Stage 2: products
   logic          s2_vld_ff;
   ctrl_type      s2_ctrl_ff, s2_ctrl_in;
   logic [PW-1:0] s2_bx_ff;
   logic [NW-1:0] s2_num_ff;
   logic [AW-1:0] s2_a_ff;
   logic [BW-1:0] s2_b_sel;

   // Stage 3: denominator
   logic          s3_vld_ff;
   ctrl_type      s3_ctrl_ff, s3_ctrl_in;
   logic [AW-1:0] s3_den_ff;
   logic [NW-1:0] s3_num_ff;

   // Division stages: index 0 is the overflow check result
   ctrl_type      dv_ctrl_in;
   logic          dv_vld_ff  [0:QB];
   ctrl_type      dv_ctrl_ff [0:QB];
   logic [AW-1:0] dv_den_ff  [0:QB];
   logic [NW-1:0] dv_rem_ff  [0:QB];
   logic [QB-1:0] dv_q_ff    [0:QB];

   // Output register
   logic        out_vld_ff;
   logic [15:0] out_val_ff, out_val_in;
   logic        out_sat_ff, out_sat_in;

   // Move everything one stage when the output can drain
   assign advance    = !out_vld_ff || rsp_tready;
   assign req_tready = advance;

   // Stage 1: register the request
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_tvalid;
      end
      if (advance) begin
         s1_x_ff   <= req_tdata;
         s1_sel_ff <= req_tuser;
      end
   end

   // Stage 2: classify, form the direct result and the two products
   always_comb begin
      s2_ctrl_in.force_sat = 1'b0;
      if (s1_sel_ff == CURVE_STD) begin
         s2_b_sel          = B_STD_FX;
         s2_ctrl_in.direct = {1'b0, s1_x_ff} + {1'b0, STD_OFFSET};
      end else begin
         s2_b_sel          = B_ENV_FX;
         s2_ctrl_in.direct = {1'b0, s1_x_ff} + {1'b0, ENV_OFFSET};
      end
      if (s1_x_ff <= 16'd1) begin
         s2_ctrl_in.kind = KIND_SMALL;
      end else if ((s1_sel_ff == CURVE_STD && s1_x_ff <= STD_LIMIT) ||
                   (s1_sel_ff == CURVE_ENV && s1_x_ff <= ENV_LIMIT)) begin
         s2_ctrl_in.kind = KIND_CURVE;
      end else begin
         s2_ctrl_in.kind = KIND_OFFSET;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (advance) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (advance) begin
         s2_ctrl_ff <= s2_ctrl_in;
         s2_bx_ff   <= PW'(s2_b_sel) * PW'(s1_x_ff);
         s2_num_ff  <= NW'(K_FX) * NW'(s1_x_ff);
         s2_a_ff    <= (s1_sel_ff == CURVE_STD) ? A_STD_FX : A_ENV_FX;
      end
   end

   // Stage 3: denominator, flag a nonpositive one
   always_comb begin
      s3_ctrl_in = s2_ctrl_ff;
      if (PW'(s2_a_ff) <= s2_bx_ff) begin
         s3_ctrl_in.force_sat = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (advance) begin
         s3_vld_ff <= s2_vld_ff;
      end
      if (advance) begin
         s3_ctrl_ff <= s3_ctrl_in;
         s3_den_ff  <= s2_a_ff - AW'(s2_bx_ff);
         s3_num_ff  <= s2_num_ff;
      end
   end

   // Stage 4: saturate when the quotient cannot fit in 16 bits
   always_comb begin
      dv_ctrl_in = s3_ctrl_ff;
      if (s3_num_ff >= {s3_den_ff, {QB{1'b0}}}) begin
         dv_ctrl_in.force_sat = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (advance) begin
         dv_vld_ff[0] <= s3_vld_ff;
      end
      if (advance) begin
         dv_ctrl_ff[0] <= dv_ctrl_in;
         dv_den_ff[0]  <= s3_den_ff;
         dv_rem_ff[0]  <= s3_num_ff;
         dv_q_ff[0]    <= '0;
      end
   end

   // Restoring division, one quotient bit per stage from the top
   for (genvar s = 0; s < QB; s++) begin : g_div
      localparam int BIT = QB - 1 - s;
      logic [NW-1:0] trial;
      logic          take;

      always_comb begin
         trial = NW'(dv_den_ff[s]) << BIT;
         take  = dv_rem_ff[s] >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[s+1] <= 1'b0;
         end else if (advance) begin
            dv_vld_ff[s+1] <= dv_vld_ff[s];
         end
         if (advance) begin
            dv_ctrl_ff[s+1] <= dv_ctrl_ff[s];
            dv_den_ff[s+1]  <= dv_den_ff[s];
            dv_rem_ff[s+1]  <= take ? dv_rem_ff[s] - trial : dv_rem_ff[s];
            dv_q_ff[s+1]    <= dv_q_ff[s] | (QB'(take) << BIT);
         end
      end
   end

   // Pick the result and clamp it
   always_comb begin
      out_val_in = 16'd1;
      out_sat_in = 1'b0;
      case (dv_ctrl_ff[QB].kind)
         KIND_SMALL: begin
            out_val_in = 16'd1;
         end
         KIND_CURVE: begin
            if (dv_ctrl_ff[QB].force_sat) begin
               out_val_in = MAX16;
               out_sat_in = 1'b1;
            end else begin
               out_val_in = dv_q_ff[QB];
            end
         end
         KIND_OFFSET: begin
            if (dv_ctrl_ff[QB].direct[16]) begin
               out_val_in = MAX16;
               out_sat_in = 1'b1;
            end else begin
               out_val_in = dv_ctrl_ff[QB].direct[15:0];
            end
         end
         default: begin
            out_val_in = 16'd1;
         end
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= dv_vld_ff[QB];
      end
      if (advance) begin
         out_val_ff <= out_val_in;
         out_sat_ff <= out_sat_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_val_ff;
   assign rsp_tuser  = out_sat_ff;

`ifndef SYNTHESIS
   // A clamped response carries the full-scale value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == MAX16)
      else $error("saturated response without full-scale value");

   // No rule yields zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata != 16'd0)
      else $error("zero corrected value");

   // Input side opens exactly when the output can drain
   assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready out of step with response side");

   // A held pipeline keeps its response
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");
`endif

endmodule
